### design/dssf_pkg.sv
// Shared types, command bytes and segment table for the decimal seven-segment frame block.
// No dependencies; used by the front, queue, back and top-level modules.
`default_nettype none

package dssf_pkg;

    localparam logic [7:0] CMD_ACTIVATE = 8'h8f;
    localparam logic [7:0] CMD_DATA     = 8'h40;
    localparam logic [7:0] CMD_ADDR     = 8'hc0;
    localparam logic [7:0] PAD_BYTE     = 8'h00;
    localparam logic [7:0] BLANK_SEG    = 8'h00;

    localparam int unsigned VALUE_W = 14;
    localparam int unsigned PROD_W  = 29;
    localparam int unsigned IDX_W   = 4;

    localparam logic [PROD_W-1:0] RECIP_1000 = 29'd16778;
    localparam logic [PROD_W-1:0] RECIP_100  = 29'd20972;
    localparam logic [PROD_W-1:0] RECIP_10   = 29'd13108;

    localparam logic [IDX_W-1:0] IDX_DATA_CMD = 4'd0;
    localparam logic [IDX_W-1:0] IDX_ADDR_CMD = 4'd1;
    localparam logic [IDX_W-1:0] IDX_LAST     = 4'd9;

    typedef logic [3:0][7:0] seg_codes_t;

    typedef struct packed {
        logic       is_num;
        seg_codes_t codes;
    } entry_t;

    function automatic logic [7:0] seg_code(input logic [4:0] digit);
        logic [7:0] code;
        case (digit)
            5'd0:    code = 8'h3f;
            5'd1:    code = 8'h06;
            5'd2:    code = 8'h5b;
            5'd3:    code = 8'h4f;
            5'd4:    code = 8'h66;
            5'd5:    code = 8'h6d;
            5'd6:    code = 8'h7d;
            5'd7:    code = 8'h07;
            5'd8:    code = 8'h7f;
            5'd9:    code = 8'h6f;
            default: code = BLANK_SEG;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

### design/dssf_front.sv
// Front end: accepts requests and splits numbers into segment codes over two stages.
// Depends on dssf_pkg for the reciprocal constants, segment table and entry type.
`default_nettype none

module dssf_front (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             push,
    output logic                                  full,
    input  wire logic                             mode,
    input  wire logic [dssf_pkg::VALUE_W-1:0]     value,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output dssf_pkg::entry_t                      out_entry
);

    logic                             advance;
    logic                             s1_valid_reg;
    logic                             s1_valid_next;
    logic                             s1_mode_reg;
    logic [dssf_pkg::VALUE_W-1:0]     s1_value_reg;
    logic [4:0]                       s1_q1000_reg;
    logic [7:0]                       s1_q100_reg;
    logic [10:0]                      s1_q10_reg;
    logic                             s2_valid_reg;
    logic                             s2_valid_next;
    dssf_pkg::entry_t                 s2_entry_reg;
    dssf_pkg::entry_t                 s2_entry_next;

    logic [dssf_pkg::PROD_W-1:0]      prod_1000;
    logic [dssf_pkg::PROD_W-1:0]      prod_100;
    logic [dssf_pkg::PROD_W-1:0]      prod_10;
    logic [7:0]                       d2_full;
    logic [10:0]                      d1_full;
    logic [13:0]                      d0_full;

    assign advance   = !s2_valid_reg || out_ready;
    assign full      = !advance;
    assign out_valid = s2_valid_reg;
    assign out_entry = s2_entry_reg;

    assign prod_1000 = dssf_pkg::PROD_W'(value) * dssf_pkg::RECIP_1000;
    assign prod_100  = dssf_pkg::PROD_W'(value) * dssf_pkg::RECIP_100;
    assign prod_10   = dssf_pkg::PROD_W'(value) * dssf_pkg::RECIP_10;

    assign s1_valid_next = push;

    assign d2_full = s1_q100_reg - 8'(s1_q1000_reg) * 8'd10;
    assign d1_full = s1_q10_reg - 11'(s1_q100_reg) * 11'd10;
    assign d0_full = s1_value_reg - 14'(s1_q10_reg) * 14'd10;

    always_comb
    begin
        s2_valid_next          = s1_valid_reg;
        s2_entry_next.is_num   = s1_mode_reg;
        s2_entry_next.codes[0] = dssf_pkg::seg_code(s1_q1000_reg);
        s2_entry_next.codes[1] = dssf_pkg::seg_code({1'b0, d2_full[3:0]});
        s2_entry_next.codes[2] = dssf_pkg::seg_code({1'b0, d1_full[3:0]});
        s2_entry_next.codes[3] = dssf_pkg::seg_code({1'b0, d0_full[3:0]});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_mode_reg  <= mode;
            s1_value_reg <= value;
            s1_q1000_reg <= prod_1000[28:24];
            s1_q100_reg  <= prod_100[28:21];
            s1_q10_reg   <= prod_10[27:17];
            s2_entry_reg <= s2_entry_next;
        end
    end

endmodule

`default_nettype wire

### design/dssf_queue.sv
// Short queue of classified entries between the front end and the byte sequencer.
// Depends on dssf_pkg for the entry type.
`default_nettype none

module dssf_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire dssf_pkg::entry_t  in_entry,
    output logic                   head_valid,
    input  wire logic              head_pop,
    output dssf_pkg::entry_t       head_entry
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    dssf_pkg::entry_t   entries_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign in_ready   = (count_reg != CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = entries_reg[rd_ptr_reg];
    assign do_push    = in_valid && in_ready;
    assign do_pop     = head_pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= in_entry;
        end
    end

endmodule

`default_nettype wire

### design/dssf_back.sv
// Back end: walks the head entry byte by byte into a one-deep output register.
// Depends on dssf_pkg for command bytes, byte positions and the entry type.
`default_nettype none

module dssf_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              head_valid,
    output logic                   head_pop,
    input  wire dssf_pkg::entry_t  head_entry,
    output logic                   empty,
    input  wire logic              pop,
    output logic [7:0]             data_byte,
    output logic                   strobe_end,
    output logic                   last
);

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [7:0]                    byte_reg;
    logic [7:0]                    byte_next;
    logic                          strobe_end_reg;
    logic                          strobe_end_next;
    logic                          last_reg;
    logic                          last_next;
    logic [dssf_pkg::IDX_W-1:0]    idx_reg;
    logic [dssf_pkg::IDX_W-1:0]    idx_next;
    logic                          load;
    logic [1:0]                    digit_sel;

    assign empty      = !out_valid_reg;
    assign data_byte  = byte_reg;
    assign strobe_end = strobe_end_reg;
    assign last       = last_reg;

    assign load      = head_valid && (!out_valid_reg || pop);
    assign digit_sel = 2'(idx_reg[3:1] - 3'd1);

    always_comb
    begin
        byte_next       = dssf_pkg::CMD_ACTIVATE;
        strobe_end_next = 1'b1;
        last_next       = 1'b1;
        if (head_entry.is_num)
        begin
            case (idx_reg)
                dssf_pkg::IDX_DATA_CMD:
                begin
                    byte_next = dssf_pkg::CMD_DATA;
                    last_next = 1'b0;
                end
                dssf_pkg::IDX_ADDR_CMD:
                begin
                    byte_next = dssf_pkg::CMD_ADDR;
                    last_next = 1'b0;
                end
                default:
                begin
                    byte_next       = idx_reg[0] ? head_entry.codes[digit_sel]
                                                 : dssf_pkg::PAD_BYTE;
                    strobe_end_next = (idx_reg == dssf_pkg::IDX_LAST);
                    last_next       = (idx_reg == dssf_pkg::IDX_LAST);
                end
            endcase
        end
    end

    always_comb
    begin
        head_pop       = load && last_next;
        out_valid_next = out_valid_reg;
        idx_next       = idx_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            idx_next       = last_next ? '0 : idx_reg + 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg       <= byte_next;
            strobe_end_reg <= strobe_end_next;
            last_reg       <= last_next;
        end
    end

endmodule

`default_nettype wire

### design/decimal_seven_segment_frame_top.sv
// Top level of the decimal seven-segment frame generator.
// Depends on dssf_pkg, dssf_front, dssf_queue and dssf_back.
//
// Input side is a queue write port: an item transfers on a clock edge with push high and
// full low. mode 0 asks for the activate command; mode 1 shows value as four decimal digits.
// Output side is a queue read port: while empty is low, data_byte, strobe_end and last hold
// the oldest byte, and it transfers on an edge with pop high.
// An activate request yields one byte (0x8f); a number yields ten bytes: 0x40, 0xc0, then
// 0x00 and a segment code for each digit, thousands first. Thousands above nine are blank.
// An item passes the first and second front stages, the queue and the output register.
// The byte sequencer emits one byte per cycle while the queue holds an entry and pop is high.
// The front end keeps accepting while the sequencer works until the queue fills and the
// second front stage holds an entry; then full rises.
// When pop stays low the output register holds its byte and the pipeline stalls behind it.
// Reset clears all valid flags, the queue pointers and count, and the byte counter; nothing else.
`default_nettype none

module decimal_seven_segment_frame_top #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             push,
    output logic                                  full,
    input  wire logic                             mode,
    input  wire logic [dssf_pkg::VALUE_W-1:0]     value,
    output logic                                  empty,
    input  wire logic                             pop,
    output logic [7:0]                            data_byte,
    output logic                                  strobe_end,
    output logic                                  last
);

    logic              front_valid;
    logic              front_ready;
    dssf_pkg::entry_t  front_entry;
    logic              head_valid;
    logic              head_pop;
    dssf_pkg::entry_t  head_entry;

    dssf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .mode      (mode),
        .value     (value),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_entry (front_entry)
    );

    dssf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (front_valid),
        .in_ready   (front_ready),
        .in_entry   (front_entry),
        .head_valid (head_valid),
        .head_pop   (head_pop),
        .head_entry (head_entry)
    );

    dssf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_pop   (head_pop),
        .head_entry (head_entry),
        .empty      (empty),
        .pop        (pop),
        .data_byte  (data_byte),
        .strobe_end (strobe_end),
        .last       (last)
    );

    a_last_ends_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && last) |-> strobe_end)
        else $error("final byte without strobe end");

    a_activate_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && data_byte == dssf_pkg::CMD_ACTIVATE) |-> (strobe_end && last))
        else $error("activate command not a single-byte frame");

    a_addr_follows_data: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && data_byte == dssf_pkg::CMD_DATA && strobe_end && !last)
        |=> (!empty && data_byte == dssf_pkg::CMD_ADDR))
        else $error("address command did not follow data command");

endmodule

`default_nettype wire
